/* src/lcs_pkg.sv */
// shared constants, codes and types of the lcs engine
package lcs_pkg;

	// longest string that the engine holds
	localparam int MAX_LEN = 32;

	// payload widths
	localparam int ModeW = 2;
	localparam int SymW = 8;
	localparam int LenFieldW = 6;
	localparam int LenFieldMax = 2 ** LenFieldW - 1;

	// internal widths
	localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LenW = $clog2(MAX_LEN + 1);
	localparam int DirDepth = MAX_LEN * MAX_LEN;
	localparam int DirAW = (DirDepth > 1) ? $clog2(DirDepth) : 1;
	localparam int DirW = 2;

	// request modes
	typedef enum logic [ModeW-1:0] {
		MODE_LOAD_FIRST  = 2'd0,
		MODE_LOAD_SECOND = 2'd1,
		MODE_RUN         = 2'd2
	} lcs_mode_t;

	// traceback directions stored per cell
	typedef enum logic [DirW-1:0] {
		DIR_DIAG  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_ABOVE = 2'd3
	} lcs_dir_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TB_READ,
		ST_TB_STEP,
		ST_EMIT
	} lcs_state_t;

	// result of one cell evaluation
	typedef struct packed {
		logic [LenW-1:0] score;
		lcs_dir_t        code;
	} lcs_cell_t;

endpackage

/* src/lcs_if.sv */
// request and result channel interfaces of the lcs engine
interface lcs_in_if;
	import lcs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ModeW-1:0]     mode;
	logic [SymW-1:0]      symbol;

	modport source (output valid, output mode, output symbol, input ready);
	modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface lcs_out_if;
	import lcs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [LenFieldW-1:0] lcs_length;
	logic [SymW-1:0]      out_char;
	logic                 has_char;
	logic                 last;
	logic                 overflow;

	modport source (output valid, output lcs_length, output out_char, output has_char,
		output last, output overflow, input ready);
	modport sink (input valid, input lcs_length, input out_char, input has_char,
		input last, input overflow, output ready);
endinterface

/* src/lcs_dir_ram.sv */
// simple dual-port ram with registered read, holds the direction table
module lcs_dir_ram #(
	parameter int Depth = 1024,
	parameter int Width = 2
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/lcs_cell_unit.sv */
// shared score unit: evaluates one cell of the score table
module lcs_cell_unit (
	input  logic [lcs_pkg::SymW-1:0] row_char,
	input  logic [lcs_pkg::SymW-1:0] col_char,
	input  logic [lcs_pkg::LenW-1:0] diag,
	input  logic [lcs_pkg::LenW-1:0] left,
	input  logic [lcs_pkg::LenW-1:0] above,
	output lcs_pkg::lcs_cell_t       cell_out
);
	import lcs_pkg::*;

	// match extends the diagonal, else larger neighbor with left taking ties
	always_comb begin
		if (row_char == col_char) begin
			cell_out.score = diag + LenW'(1);
			cell_out.code  = DIR_DIAG;
		end else if (left >= above) begin
			cell_out.score = left;
			cell_out.code  = DIR_LEFT;
		end else begin
			cell_out.score = above;
			cell_out.code  = DIR_ABOVE;
		end
	end

endmodule

/* src/lcs_length_and_traceback.sv */
// Longest common subsequence engine. A load request (mode 0 or 1) appends one byte to the
// first or second string; bytes past MAX_LEN are dropped and flag overflow. A run request
// (mode 2) fills the nr by nc score table, where nr and nc are the shorter and longer string
// lengths (one cell per cycle through the single score unit), then walks back at most nr+nc
// steps, each a read of the direction memory's registered port in ST_TB_READ and a move in
// ST_TB_STEP, then emits the results, each held until the sink takes it. The score row
// clears through per-entry valid bits, so there is no clearing pass after reset. The engine
// takes no request from the start of a run until its last result has been taken.
module lcs_length_and_traceback (
	input  logic      clk,
	input  logic      arst_n,
	lcs_in_if.sink    item,
	lcs_out_if.source result
);
	import lcs_pkg::*;

	lcs_state_t state_q, state_d;

	// string storage and counts
	logic [SymW-1:0] first_str_q  [MAX_LEN];
	logic [SymW-1:0] second_str_q [MAX_LEN];
	logic [LenW-1:0] first_cnt_q, second_cnt_q;
	logic            ovf_q;

	// score row with valid bits standing for the zero row
	logic [LenW-1:0]    row_sc_q [MAX_LEN];
	logic [MAX_LEN-1:0] row_vld_q;

	// run registers
	logic            swap_q;
	logic [LenW-1:0] nr_q, nc_q;
	logic [IdxW-1:0] ri_q, cj_q;
	logic [LenW-1:0] left_q, diag_q;
	logic [LenW-1:0] len_q, k_q;
	logic [LenW-1:0] ti_q, tj_q;
	logic [IdxW-1:0] ek_q;
	logic [SymW-1:0] path_q [MAX_LEN];

	lcs_mode_t       req_mode;
	logic            req_take;
	logic [LenW-1:0] run_nr;
	logic            fill_row_end, fill_last;
	logic [IdxW-1:0] tb_ri, tb_cj, row_addr, first_addr, second_addr;
	logic [SymW-1:0] first_ch, second_ch, row_char, col_char;
	logic [LenW-1:0] above;
	lcs_cell_t       cell_res;
	logic            dir_we;
	logic [DirAW-1:0] dir_waddr, dir_raddr;
	logic [DirW-1:0] dir_rdata;
	lcs_dir_t        tb_code;
	logic [LenW-1:0] ti_nx, tj_nx;
	logic            tb_more;
	logic            out_last, out_take;
	logic [LenW:0]   len_ext;

	assign req_mode = lcs_mode_t'(item.mode);
	assign req_take = item.valid && item.ready;
	assign out_take = result.valid && result.ready;
	assign run_nr   = (first_cnt_q > second_cnt_q) ? second_cnt_q : first_cnt_q;

	// fill position checks
	assign fill_row_end = (LenW'(cj_q) + LenW'(1)) == nc_q;
	assign fill_last    = fill_row_end && ((LenW'(ri_q) + LenW'(1)) == nr_q);

	// string reads, roles swap when the first string is longer
	assign tb_ri       = IdxW'(ti_q - LenW'(1));
	assign tb_cj       = IdxW'(tj_q - LenW'(1));
	assign row_addr    = (state_q == ST_FILL) ? ri_q : tb_ri;
	assign first_addr  = swap_q ? cj_q : row_addr;
	assign second_addr = swap_q ? row_addr : cj_q;
	assign first_ch    = first_str_q[first_addr];
	assign second_ch   = second_str_q[second_addr];
	assign row_char    = swap_q ? second_ch : first_ch;
	assign col_char    = swap_q ? first_ch : second_ch;
	assign above       = row_vld_q[cj_q] ? row_sc_q[cj_q] : '0;

	lcs_cell_unit u_cell (
		.row_char (row_char),
		.col_char (col_char),
		.diag     (diag_q),
		.left     (left_q),
		.above    (above),
		.cell_out (cell_res)
	);

	// direction table
	assign dir_waddr = DirAW'(ri_q) * DirAW'(MAX_LEN) + DirAW'(cj_q);
	assign dir_raddr = DirAW'(tb_ri) * DirAW'(MAX_LEN) + DirAW'(tb_cj);

	lcs_dir_ram #(
		.Depth (DirDepth),
		.Width (DirW)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (cell_res.code),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	// traceback step
	assign tb_code = lcs_dir_t'(dir_rdata);
	always_comb begin
		ti_nx = ti_q;
		tj_nx = tj_q;
		case (tb_code)
			DIR_DIAG: begin
				ti_nx = ti_q - LenW'(1);
				tj_nx = tj_q - LenW'(1);
			end
			DIR_LEFT: begin
				tj_nx = tj_q - LenW'(1);
			end
			default: begin
				ti_nx = ti_q - LenW'(1);
			end
		endcase
	end
	assign tb_more = (ti_nx != '0) && (tj_nx != '0);

	// result payload
	assign out_last = (len_q == '0) || ((LenW'(ek_q) + LenW'(1)) == len_q);
	assign len_ext  = (LenW + 1)'(len_q);
	assign result.lcs_length = (len_ext > (LenW + 1)'(LenFieldMax)) ?
		LenFieldW'(LenFieldMax) : LenFieldW'(len_q);
	assign result.out_char = (len_q == '0) ? '0 : path_q[ek_q];
	assign result.has_char = (len_q != '0);
	assign result.last     = out_last;
	assign result.overflow = ovf_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take && (req_mode == MODE_RUN)) begin
					state_d = (run_nr == '0) ? ST_EMIT : ST_FILL;
				end
			end
			ST_FILL: begin
				if (fill_last) begin
					state_d = ST_TB_READ;
				end
			end
			ST_TB_READ: state_d = ST_TB_STEP;
			ST_TB_STEP: state_d = tb_more ? ST_TB_READ : ST_EMIT;
			ST_EMIT: begin
				if (out_take && out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and strobe outputs
	always_comb begin
		item.ready   = 1'b0;
		result.valid = 1'b0;
		dir_we       = 1'b0;
		case (state_q)
			ST_IDLE: item.ready   = 1'b1;
			ST_FILL: dir_we       = 1'b1;
			ST_EMIT: result.valid = 1'b1;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counts, overflow flag and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			ovf_q        <= 1'b0;
			row_vld_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						case (req_mode)
							MODE_LOAD_FIRST: begin
								if (first_cnt_q < LenW'(MAX_LEN)) begin
									first_cnt_q <= first_cnt_q + LenW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							MODE_LOAD_SECOND: begin
								if (second_cnt_q < LenW'(MAX_LEN)) begin
									second_cnt_q <= second_cnt_q + LenW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							MODE_RUN: row_vld_q <= '0;
							default: ;
						endcase
					end
				end
				ST_FILL: row_vld_q[cj_q] <= 1'b1;
				ST_EMIT: begin
					if (out_take && out_last) begin
						first_cnt_q  <= '0;
						second_cnt_q <= '0;
						ovf_q        <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					case (req_mode)
						MODE_LOAD_FIRST: begin
							if (first_cnt_q < LenW'(MAX_LEN)) begin
								first_str_q[IdxW'(first_cnt_q)] <= item.symbol;
							end
						end
						MODE_LOAD_SECOND: begin
							if (second_cnt_q < LenW'(MAX_LEN)) begin
								second_str_q[IdxW'(second_cnt_q)] <= item.symbol;
							end
						end
						MODE_RUN: begin
							swap_q <= first_cnt_q > second_cnt_q;
							nr_q   <= run_nr;
							nc_q   <= (first_cnt_q > second_cnt_q) ? first_cnt_q : second_cnt_q;
							ri_q   <= '0;
							cj_q   <= '0;
							left_q <= '0;
							diag_q <= '0;
							len_q  <= '0;
							ek_q   <= '0;
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				row_sc_q[cj_q] <= cell_res.score;
				if (fill_row_end) begin
					cj_q   <= '0;
					left_q <= '0;
					diag_q <= '0;
					if (fill_last) begin
						len_q <= cell_res.score;
						k_q   <= cell_res.score;
						ti_q  <= nr_q;
						tj_q  <= nc_q;
					end else begin
						ri_q <= ri_q + IdxW'(1);
					end
				end else begin
					cj_q   <= cj_q + IdxW'(1);
					left_q <= cell_res.score;
					diag_q <= above;
				end
			end
			ST_TB_STEP: begin
				ti_q <= ti_nx;
				tj_q <= tj_nx;
				if ((tb_code == DIR_DIAG) && (k_q != '0)) begin
					k_q <= k_q - LenW'(1);
					path_q[IdxW'(k_q - LenW'(1))] <= row_char;
				end
			end
			ST_EMIT: begin
				if (out_take && !out_last) begin
					ek_q <= ek_q + IdxW'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// requests and results never open at once
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("request and result channels open together");

	// fill position stays inside the loaded strings
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> ((LenW'(ri_q) < nr_q) && (LenW'(cj_q) < nc_q) && (nr_q <= nc_q)))
		else $error("fill index outside table");

	// emit index stays below the length
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (len_q != '0)) |-> (LenW'(ek_q) < len_q))
		else $error("emit index past subsequence length");

	// traceback only walks inside the table
	a_tb_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TB_READ) |-> ((ti_q != '0) && (tj_q != '0) && (ti_q <= nr_q)
			&& (tj_q <= nc_q)))
		else $error("traceback outside table");

	// the last result empties the strings and the flag
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && result.last) |=> ((first_cnt_q == '0) && (second_cnt_q == '0) && !ovf_q))
		else $error("run did not clear loaded state");
`endif

endmodule

/* verif/lcs_length_and_traceback_tb.sv */
// self-checking testbench of the lcs engine with a built-in predictor of its results
module lcs_length_and_traceback_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcs_pkg::*;

	// mode code the engine must ignore
	localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 24;

	// one expected result of a run
	typedef struct packed {
		logic [LenFieldW-1:0] lcs_length;
		logic [SymW-1:0]      out_char;
		logic                 has_char;
		logic                 last;
		logic                 overflow;
	} lcs_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lcs_in_if  item_ch ();
	lcs_out_if result_ch ();

	lcs_length_and_traceback dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [SymW-1:0] first_bytes[MAX_LEN];
	logic [SymW-1:0] second_bytes[MAX_LEN];
	int              first_fill = 0;
	int              second_fill = 0;
	bit              dropped_flag = 1'b0;
	lcs_beat_t       expected_beats[$];

	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int sink_stall_pct = 0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("lcs_length_and_traceback test failed");
			$finish;
		end
	end

	// result side ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// score table fill, traceback and result prediction for a run request
	function automatic void predict_subsequence();
		logic [SymW-1:0] rows[MAX_LEN];
		logic [SymW-1:0] cols[MAX_LEN];
		logic [SymW-1:0] path[MAX_LEN];
		int              score[MAX_LEN+1][MAX_LEN+1];
		lcs_dir_t        dirs[MAX_LEN][MAX_LEN];
		int              nr, nc, i, j, k, len;
		lcs_beat_t       beat;

		// shorter string indexes the rows
		if (first_fill > second_fill) begin
			rows = second_bytes;
			cols = first_bytes;
			nr = second_fill;
			nc = first_fill;
		end else begin
			rows = first_bytes;
			cols = second_bytes;
			nr = first_fill;
			nc = second_fill;
		end

		for (j = 0; j <= nc; j++) score[0][j] = 0;
		for (i = 1; i <= nr; i++) begin
			score[i][0] = 0;
			for (j = 1; j <= nc; j++) begin
				if (rows[i-1] == cols[j-1]) begin
					score[i][j] = score[i-1][j-1] + 1;
					dirs[i-1][j-1] = DIR_DIAG;
				end else if (score[i][j-1] >= score[i-1][j]) begin
					score[i][j] = score[i][j-1];
					dirs[i-1][j-1] = DIR_LEFT;
				end else begin
					score[i][j] = score[i-1][j];
					dirs[i-1][j-1] = DIR_ABOVE;
				end
			end
		end
		len = score[nr][nc];

		// walk back from the last cell, filling the path from its end
		i = nr;
		j = nc;
		k = len;
		while (i > 0 && j > 0) begin
			case (dirs[i-1][j-1])
				DIR_DIAG: begin
					if (k > 0) begin
						k--;
						path[k] = rows[i-1];
					end
					i--;
					j--;
				end
				DIR_LEFT: j--;
				default: i--;
			endcase
		end

		// one result per character, or a single empty one
		if (len == 0) begin
			beat = '{lcs_length: '0, out_char: '0, has_char: 1'b0, last: 1'b1,
				overflow: dropped_flag};
			expected_beats.push_back(beat);
		end else begin
			for (k = 0; k < len; k++) begin
				beat.lcs_length = (len > LenFieldMax) ? LenFieldW'(LenFieldMax) : LenFieldW'(len);
				beat.out_char = path[k];
				beat.has_char = 1'b1;
				beat.last = (k + 1 == len);
				beat.overflow = dropped_flag;
				expected_beats.push_back(beat);
			end
		end

		first_fill = 0;
		second_fill = 0;
		dropped_flag = 1'b0;
	endfunction

	// state update for one accepted request
	function automatic void track_request(input logic [ModeW-1:0] m, input logic [SymW-1:0] s);
		case (m)
			MODE_LOAD_FIRST: begin
				if (first_fill < MAX_LEN) begin
					first_bytes[first_fill] = s;
					first_fill++;
				end else begin
					dropped_flag = 1'b1;
				end
			end
			MODE_LOAD_SECOND: begin
				if (second_fill < MAX_LEN) begin
					second_bytes[second_fill] = s;
					second_fill++;
				end else begin
					dropped_flag = 1'b1;
				end
			end
			MODE_RUN: predict_subsequence();
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		lcs_beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				note_failure($sformatf("unexpected result: len %0d char %02h has %0b last %0b ovf %0b",
					result_ch.lcs_length, result_ch.out_char, result_ch.has_char,
					result_ch.last, result_ch.overflow));
			end else begin
				want = expected_beats.pop_front();
				if (result_ch.lcs_length !== want.lcs_length || result_ch.out_char !== want.out_char
						|| result_ch.has_char !== want.has_char || result_ch.last !== want.last
						|| result_ch.overflow !== want.overflow) begin
					note_failure($sformatf({"mismatch: expected len %0d char %02h has %0b last %0b ",
						"ovf %0b, got len %0d char %02h has %0b last %0b ovf %0b"},
						want.lcs_length, want.out_char, want.has_char, want.last, want.overflow,
						result_ch.lcs_length, result_ch.out_char, result_ch.has_char,
						result_ch.last, result_ch.overflow));
				end
			end
		end
	end

	// send one request, with random idle cycles ahead of it
	task automatic send_request(input logic [ModeW-1:0] m, input logic [SymW-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.symbol <= s;
		do @(posedge clk); while (!item_ch.ready);
		track_request(m, s);
	endtask

	// hold the sender off until every expected result has come
	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
	endtask

	// run on two empty strings
	task automatic test_empty_run();
		send_request(MODE_RUN, 8'h5a);
	endtask

	// run with only one string loaded
	task automatic test_one_empty_string();
		send_request(MODE_LOAD_FIRST, 8'h00);
		send_request(MODE_RUN, 8'hff);
	endtask

	// extreme byte values, first string longer so the roles swap
	task automatic test_extreme_symbols();
		send_request(MODE_LOAD_FIRST, 8'hff);
		send_request(MODE_LOAD_FIRST, 8'h00);
		send_request(MODE_LOAD_FIRST, 8'hff);
		send_request(MODE_LOAD_SECOND, 8'h00);
		send_request(MODE_LOAD_SECOND, 8'hff);
		send_request(MODE_RUN, 8'h00);
	endtask

	// unused mode between loads changes nothing
	task automatic test_unused_mode();
		send_request(MODE_LOAD_FIRST, 8'h41);
		send_request(MODE_UNUSED, 8'h42);
		send_request(MODE_LOAD_SECOND, 8'h41);
		send_request(MODE_UNUSED, 8'hff);
		send_request(MODE_RUN, 8'h00);
	endtask

	// equal left and above scores pick the left cell
	task automatic test_tie_break();
		send_request(MODE_LOAD_FIRST, 8'h41);
		send_request(MODE_LOAD_FIRST, 8'h42);
		send_request(MODE_LOAD_SECOND, 8'h42);
		send_request(MODE_LOAD_SECOND, 8'h41);
		send_request(MODE_RUN, 8'h00);
	endtask

	// random load sequences closed by a run, under one idling setting
	task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct,
			input bit open_full);
		logic [SymW-1:0] alphabet[4];
		int              sent, len_a, len_b, left_a, left_b, alpha_n, pick, k;
		bit              narrow, full_next;
		logic [SymW-1:0] sym;

		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		full_next = open_full;
		while (sent < n_items) begin
			// string lengths: mostly short, some long, a few past the end
			if (full_next) begin
				len_a = MAX_LEN;
				len_b = MAX_LEN;
				if ($urandom_range(1)) len_a += $urandom_range(2, 1);
				else len_b += $urandom_range(2, 1);
				full_next = 1'b0;
			end else begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					len_a = $urandom_range(8);
					len_b = $urandom_range(8);
				end else if (pick < 95) begin
					len_a = $urandom_range(MAX_LEN, 9);
					len_b = $urandom_range(MAX_LEN);
				end else begin
					len_a = $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
					len_b = $urandom_range(MAX_LEN + 4);
				end
				if ($urandom_range(1)) begin
					k = len_a;
					len_a = len_b;
					len_b = k;
				end
			end

			// small alphabets make long common subsequences
			narrow = ($urandom_range(99) < 70);
			alpha_n = $urandom_range(4, 1);
			for (k = 0; k < 4; k++) alphabet[k] = SymW'($urandom_range(255));

			left_a = len_a;
			left_b = len_b;
			while (left_a + left_b > 0) begin
				if ($urandom_range(99) < 4) send_request(MODE_UNUSED, SymW'($urandom_range(255)));
				sym = narrow ? alphabet[$urandom_range(alpha_n - 1)] : SymW'($urandom_range(255));
				if (left_b == 0 || (left_a > 0 && $urandom_range(1))) begin
					send_request(MODE_LOAD_FIRST, sym);
					left_a--;
				end else begin
					send_request(MODE_LOAD_SECOND, sym);
					left_b--;
				end
				sent++;
			end
			send_request(MODE_RUN, SymW'($urandom_range(255)));
			sent++;
			if ($urandom_range(99) < 10) wait_for_drain();
		end
		wait_for_drain();
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_LOAD_FIRST;
		item_ch.symbol <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_run();
		test_one_empty_string();
		test_extreme_symbols();
		test_unused_mode();
		test_tie_break();
		wait_for_drain();

		test_random_phase(60, 0, 0, 1'b1);
		test_random_phase(60, 61, 0, 1'b0);
		test_random_phase(60, 0, 61, 1'b0);
		test_random_phase(60, 20, 20, 1'b1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) begin
			note_failure($sformatf("%0d expected results never came", expected_beats.size()));
		end
		if (fail_count == 0) begin
			$display("lcs_length_and_traceback test passed");
		end else begin
			$display("lcs_length_and_traceback test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/lcs_pkg.sv
src/lcs_if.sv
src/lcs_dir_ram.sv
src/lcs_cell_unit.sv
src/lcs_length_and_traceback.sv
verif/lcs_length_and_traceback_tb.sv
